[hw/rtl/kgts_pkg.sv]
// ----------------------------------------------------------------------------
// kgts_pkg
// Shared types, constants and helpers for the group telegram sender.
// ----------------------------------------------------------------------------
package kgts_pkg;

    localparam int HEADER_BYTES = 6;
    localparam int MAX_BYTES    = 23;
    localparam int MAX_PAYLOAD  = 16;
    localparam int IDX_W        = $clog2(MAX_BYTES);
    localparam int PLEN_W       = 5;
    localparam int PLM1_W       = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;

    localparam logic [7:0] CTRL_FIELD   = 8'hBC;
    localparam logic [7:0] ROUTE_NIBBLE = 8'hE0;

    // frame byte positions
    localparam int BYTE_CTRL     = 0;
    localparam int BYTE_SRC_HI   = 1;
    localparam int BYTE_SRC_LO   = 2;
    localparam int BYTE_DST_HI   = 3;
    localparam int BYTE_DST_LO   = 4;
    localparam int BYTE_ROUTE    = 5;
    localparam int BYTE_CMD_HI   = 6;
    localparam int BYTE_CMD_DATA = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_AREA   = 3'd0,
        CFG_SOURCE_LINE   = 3'd1,
        CFG_SOURCE_MEMBER = 3'd2,
        CFG_CONTINUE_CODE = 3'd3,
        CFG_END_CODE      = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic [3:0] source_area;
        logic [3:0] source_line;
        logic [7:0] source_member;
        logic [7:0] continue_code;
        logic [7:0] end_code;
    } t_cfg;

    typedef struct packed {
        logic [4:0]        main_group;
        logic [2:0]        middle_group;
        logic [7:0]        sub_group;
        logic [3:0]        command;
        logic [5:0]        first_data;
        logic [PLM1_W-1:0] plen_m1;
    } t_req;

    typedef struct packed {
        logic             load;
        logic             emit;
        logic [IDX_W-1:0] idx;
        logic             is_last;
    } t_seq_ctl;

    // payload length saturated to 1..MAX_PAYLOAD, minus one
    function automatic logic [PLM1_W-1:0] sat_plen_m1(input logic [PLEN_W-1:0] plen);
        logic [PLM1_W-1:0] res;
        if (plen == '0) begin
            res = '0;
        end else if (plen > PLEN_W'(MAX_PAYLOAD)) begin
            res = PLM1_W'(MAX_PAYLOAD - 1);
        end else begin
            res = PLM1_W'(plen - PLEN_W'(1));
        end
        return res;
    endfunction

    // index of the checksum byte
    function automatic logic [IDX_W-1:0] last_index(input logic [PLM1_W-1:0] plen_m1);
        logic [IDX_W+1:0] sum;
        logic [IDX_W-1:0] res;
        sum = (IDX_W+2)'(HEADER_BYTES + 1) + (IDX_W+2)'(plen_m1);
        if (sum > (IDX_W+2)'(MAX_BYTES - 1)) begin
            res = IDX_W'(MAX_BYTES - 1);
        end else begin
            res = IDX_W'(sum);
        end
        return res;
    endfunction

endpackage

[hw/rtl/kgts_req_if.sv]
// ----------------------------------------------------------------------------
// kgts_req_if
// Request channel: target group, command, data and payload length.
// ----------------------------------------------------------------------------
interface kgts_req_if;
    logic       valid;
    logic       ready;
    logic [4:0] main_group;
    logic [2:0] middle_group;
    logic [7:0] sub_group;
    logic [3:0] command;
    logic [5:0] first_data;
    logic [4:0] payload_length;

    modport source (
        output valid, main_group, middle_group, sub_group, command, first_data,
               payload_length,
        input  ready
    );
    modport sink (
        input  valid, main_group, middle_group, sub_group, command, first_data,
               payload_length,
        output ready
    );
endinterface

[hw/rtl/kgts_pair_if.sv]
// ----------------------------------------------------------------------------
// kgts_pair_if
// Transmit byte pair channel: control prefix, frame byte and last flag.
// ----------------------------------------------------------------------------
interface kgts_pair_if;
    logic       valid;
    logic       ready;
    logic [7:0] control_byte;
    logic [7:0] frame_byte;
    logic       last;

    modport source (
        output valid, control_byte, frame_byte, last,
        input  ready
    );
    modport sink (
        input  valid, control_byte, frame_byte, last,
        output ready
    );
endinterface

[hw/rtl/kgts_seq.sv]
// ----------------------------------------------------------------------------
// kgts_seq
// Byte sequencer: walks the frame index from zero to the checksum byte.
// ----------------------------------------------------------------------------
module kgts_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [kgts_pkg::IDX_W-1:0]     i_last_idx,
    input  logic                           i_out_free,
    output logic                           o_busy,
    output kgts_pkg::t_seq_ctl             o_ctl
);
    import kgts_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_last_idx;
    logic             w_emit;
    logic             w_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx      <= '0;
            r_last_idx <= i_last_idx;
        end else if (w_emit) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (w_emit && w_is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_is_last = (r_idx == r_last_idx);
        w_emit    = 1'b0;
        o_busy    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
            end
            ST_SEND: begin
                o_busy = 1'b1;
                w_emit = i_out_free;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
        o_ctl.load    = i_start;
        o_ctl.emit    = w_emit;
        o_ctl.idx     = r_idx;
        o_ctl.is_last = w_is_last;
    end

endmodule

[hw/rtl/kgts_byte.sv]
// ----------------------------------------------------------------------------
// kgts_byte
// Frame byte selector, shared checksum accumulator and output register.
// ----------------------------------------------------------------------------
module kgts_byte (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kgts_pkg::t_seq_ctl  i_ctl,
    input  kgts_pkg::t_req      i_req,
    input  kgts_pkg::t_cfg      i_cfg,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [7:0]          o_control_byte,
    output logic [7:0]          o_frame_byte,
    output logic                o_last,
    output logic                o_out_free
);
    import kgts_pkg::*;

    t_req       r_req;
    logic [7:0] r_bcc;
    logic       r_valid;
    logic [7:0] r_control_byte;
    logic [7:0] r_frame_byte;
    logic       r_last;
    logic [7:0] w_byte;
    logic [7:0] w_code;

    always_comb begin
        case (i_ctl.idx)
            IDX_W'(BYTE_CTRL):     w_byte = CTRL_FIELD;
            IDX_W'(BYTE_SRC_HI):   w_byte = {i_cfg.source_area, i_cfg.source_line};
            IDX_W'(BYTE_SRC_LO):   w_byte = i_cfg.source_member;
            IDX_W'(BYTE_DST_HI):   w_byte = {r_req.main_group, r_req.middle_group};
            IDX_W'(BYTE_DST_LO):   w_byte = r_req.sub_group;
            IDX_W'(BYTE_ROUTE):    w_byte = ROUTE_NIBBLE | 8'(r_req.plen_m1);
            IDX_W'(BYTE_CMD_HI):   w_byte = {6'd0, r_req.command[3:2]};
            IDX_W'(BYTE_CMD_DATA): w_byte = {r_req.command[1:0], r_req.first_data};
            default:               w_byte = 8'd0;
        endcase
        w_code = i_ctl.is_last ? i_cfg.end_code : i_cfg.continue_code;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req <= i_req;
            r_bcc <= 8'd0;
        end else if (i_ctl.emit && !i_ctl.is_last) begin
            r_bcc <= r_bcc ^ w_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_control_byte <= w_code | 8'(i_ctl.idx);
            r_frame_byte   <= i_ctl.is_last ? ~r_bcc : w_byte;
            r_last         <= i_ctl.is_last;
        end
    end

    assign o_out_free     = !r_valid || i_ready;
    assign o_valid        = r_valid;
    assign o_control_byte = r_control_byte;
    assign o_frame_byte   = r_frame_byte;
    assign o_last         = r_last;

endmodule

[hw/rtl/knx_group_telegram_sender_unit.sv]
// ----------------------------------------------------------------------------
// knx_group_telegram_sender_unit
// Builds a standard group telegram per request and sends it as byte pairs.
// ----------------------------------------------------------------------------
// A taken request moves the sequencer to its send state; the first pair is
// then registered at the output. Throughput: one pair per cycle while the sink
// is ready; a request with payload n gives min(max(n, 1) + 7, 23) pairs, set by
// the sequencer, one frame byte per cycle via the shared checksum accumulator.
// A new request is taken once the checksum pair is in the output register.
// Reset clears the sequencer and output valid, and restores register defaults.
module knx_group_telegram_sender_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    kgts_req_if.sink                            i_req,
    kgts_pair_if.source                         o_pair,
    input  logic                                i_cfg_we,
    input  logic [kgts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kgts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import kgts_pkg::*;

    t_cfg             r_cfg;
    t_req             w_req;
    t_seq_ctl         w_ctl;
    logic             w_busy;
    logic             w_start;
    logic             w_out_free;
    logic [IDX_W-1:0] w_last_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_area   <= 4'd4;
            r_cfg.source_line   <= 4'd7;
            r_cfg.source_member <= 8'd13;
            r_cfg.continue_code <= 8'd128;
            r_cfg.end_code      <= 8'd64;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_SOURCE_AREA:   r_cfg.source_area   <= i_cfg_data[3:0];
                CFG_SOURCE_LINE:   r_cfg.source_line   <= i_cfg_data[3:0];
                CFG_SOURCE_MEMBER: r_cfg.source_member <= i_cfg_data;
                CFG_CONTINUE_CODE: r_cfg.continue_code <= i_cfg_data;
                CFG_END_CODE:      r_cfg.end_code      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_req.ready = !w_busy;
    assign w_start     = i_req.valid && !w_busy;

    always_comb begin
        w_req.main_group   = i_req.main_group;
        w_req.middle_group = i_req.middle_group;
        w_req.sub_group    = i_req.sub_group;
        w_req.command      = i_req.command;
        w_req.first_data   = i_req.first_data;
        w_req.plen_m1      = sat_plen_m1(i_req.payload_length);
        w_last_idx         = last_index(w_req.plen_m1);
    end

    kgts_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_last_idx (w_last_idx),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_ctl      (w_ctl)
    );

    kgts_byte u_byte (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_req          (w_req),
        .i_cfg          (r_cfg),
        .i_ready        (o_pair.ready),
        .o_valid        (o_pair.valid),
        .o_control_byte (o_pair.control_byte),
        .o_frame_byte   (o_pair.frame_byte),
        .o_last         (o_pair.last),
        .o_out_free     (w_out_free)
    );

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_busy)
        else $error("sequencer not busy after request");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.emit && w_ctl.is_last) |=> (!w_busy && o_pair.valid && o_pair.last))
        else $error("checksum pair did not end the telegram");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_busy |-> !w_ctl.emit)
        else $error("pair produced while idle");

endmodule
